// File: sv/ftmc_pkg.sv
`timescale 1ns / 1ps

package ftmc_pkg;

    // Field and register widths.
    localparam int TEMP_W    = 11;
    localparam int THR_W     = 7;
    localparam int TICKS_W   = 13;
    localparam int DUTY_W    = 7;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // Default width of the tick counter.
    localparam int COUNTER_BITS_DEF = 13;

    // Register reset values.
    localparam logic [THR_W-1:0]   LOW_THR_RST   = 7'd23;
    localparam logic [THR_W-1:0]   HIGH_THR_RST  = 7'd25;
    localparam logic [THR_W-1:0]   CRIT_THR_RST  = 7'd27;
    localparam logic [TICKS_W-1:0] HOLD_RST      = 13'd3000;
    localparam logic [TICKS_W-1:0] EMERG_RST     = 13'd5000;

    // Fan duty codes in percent.
    localparam logic [DUTY_W-1:0]  DUTY_OFF      = 7'd0;
    localparam logic [DUTY_W-1:0]  DUTY_HALF     = 7'd50;
    localparam logic [DUTY_W-1:0]  DUTY_FULL     = 7'd100;

    // Register indexes (word address).
    localparam logic [2:0] REG_LOW_THR  = 3'd0;
    localparam logic [2:0] REG_HIGH_THR = 3'd1;
    localparam logic [2:0] REG_CRIT_THR = 3'd2;
    localparam logic [2:0] REG_HOLD     = 3'd3;
    localparam logic [2:0] REG_EMERG    = 3'd4;

    typedef enum logic [2:0] {
        MODE_CONNECTING = 3'd0,
        MODE_OFF        = 3'd1,
        MODE_HALF       = 3'd2,
        MODE_FULL       = 3'd3,
        MODE_EMERGENCY  = 3'd4,
        MODE_LATCHED    = 3'd5
    } mode_t;

    // Whole degrees to tenths, as a signed value wide enough for 10 * 127.
    function automatic logic signed [TEMP_W:0] tenths_of(input logic [THR_W-1:0] deg);
        logic [TEMP_W:0] sum;
        sum = {2'b00, deg, 3'b000} + {4'b0000, deg, 1'b0};
        return signed'(sum);
    endfunction

endpackage

// File: sv/fan_thermostat_mode_controller.sv
// Path: a beat accepted into the input register moves on to the result register,
// from which its result is offered.
// Throughput: one beat per cycle; the mode and counter update as each beat moves on,
// and the input stalls only while both registers hold beats and the result side stalls.
// Reset: rst_n is asynchronous and active low; mode goes to connecting, the
// tick counter to zero, and the registers to their default thresholds and lengths.
`timescale 1ns / 1ps

module fan_thermostat_mode_controller
    import ftmc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    // Input channel
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic signed [TEMP_W-1:0] temperature_tenths,
    input  logic                     sensor_error,
    input  logic                     key_pressed,

    // Result channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [DUTY_W-1:0]        fan_duty,
    output logic                     water_on,
    output logic [2:0]               mode,
    output logic                     fault_restart
);

    // The counter and the lengths are compared at a common width.
    localparam int CMP_W = (COUNTER_BITS > TICKS_W) ? COUNTER_BITS : TICKS_W;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; pready
    // is tied high, so there are no wait states.
    // ------------------------------------------------------------------
    logic [THR_W-1:0]   low_thr_reg;
    logic [THR_W-1:0]   high_thr_reg;
    logic [THR_W-1:0]   crit_thr_reg;
    logic [TICKS_W-1:0] hold_reg;
    logic [TICKS_W-1:0] emerg_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THR_RST;
            high_thr_reg <= HIGH_THR_RST;
            crit_thr_reg <= CRIT_THR_RST;
            hold_reg     <= HOLD_RST;
            emerg_reg    <= EMERG_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_LOW_THR:  low_thr_reg  <= pwdata[THR_W-1:0];
                REG_HIGH_THR: high_thr_reg <= pwdata[THR_W-1:0];
                REG_CRIT_THR: crit_thr_reg <= pwdata[THR_W-1:0];
                REG_HOLD:     hold_reg     <= pwdata[TICKS_W-1:0];
                REG_EMERG:    emerg_reg    <= pwdata[TICKS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read data is decoded straight from the address.
    always_comb
    begin
        case (paddr[4:2])
            REG_LOW_THR:  prdata = {{(DATA_W-THR_W){1'b0}}, low_thr_reg};
            REG_HIGH_THR: prdata = {{(DATA_W-THR_W){1'b0}}, high_thr_reg};
            REG_CRIT_THR: prdata = {{(DATA_W-THR_W){1'b0}}, crit_thr_reg};
            REG_HOLD:     prdata = {{(DATA_W-TICKS_W){1'b0}}, hold_reg};
            REG_EMERG:    prdata = {{(DATA_W-TICKS_W){1'b0}}, emerg_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The input register takes a beat whenever it is empty or
    // drains in the same cycle; it drains whenever the result register is
    // empty or its beat is being taken. A waiting result therefore blocks
    // the input only once the input register also holds a beat.
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic                     result_valid_reg;
    logic                     item_accept;
    logic                     advance;

    assign advance      = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = s1_valid_reg && !advance;
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Input payload register.
    logic signed [TEMP_W-1:0] temp_s1_reg;
    logic                     err_s1_reg;
    logic                     key_s1_reg;

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            temp_s1_reg <= temperature_tenths;
            err_s1_reg  <= sensor_error;
            key_s1_reg  <= key_pressed;
        end
    end

    // ------------------------------------------------------------------
    // Temperature compares. A reading is above a threshold when it is
    // strictly greater than ten times the whole-degree value, and below it
    // when strictly less.
    // ------------------------------------------------------------------
    logic signed [TEMP_W:0] temp_ext;
    logic signed [TEMP_W:0] low_tenths;
    logic signed [TEMP_W:0] high_tenths;
    logic signed [TEMP_W:0] crit_tenths;
    logic                   above_low;
    logic                   below_low;
    logic                   above_high;
    logic                   below_high;
    logic                   above_crit;

    assign temp_ext    = {temp_s1_reg[TEMP_W-1], temp_s1_reg};
    assign low_tenths  = tenths_of(low_thr_reg);
    assign high_tenths = tenths_of(high_thr_reg);
    assign crit_tenths = tenths_of(crit_thr_reg);
    assign above_low   = temp_ext > low_tenths;
    assign below_low   = temp_ext < low_tenths;
    assign above_high  = temp_ext > high_tenths;
    assign below_high  = temp_ext < high_tenths;
    assign above_crit  = temp_ext > crit_tenths;

    // ------------------------------------------------------------------
    // Mode machine and the shared tick counter. Half fan and emergency both
    // time with the same counter; it saturates at all ones, so a length that
    // the counter cannot reach never expires. A length of zero expires on
    // every tick, as a length of one does.
    // ------------------------------------------------------------------
    mode_t                   mode_reg;
    mode_t                   mode_next;
    logic [COUNTER_BITS-1:0] counter_reg;
    logic [COUNTER_BITS-1:0] counter_next;
    logic [COUNTER_BITS-1:0] counter_inc;
    logic [TICKS_W-1:0]      timer_len;
    logic                    timer_done;
    logic                    fault;

    assign counter_inc = (counter_reg == '1) ? counter_reg : counter_reg + 1'b1;
    assign timer_len   = (mode_reg == MODE_EMERGENCY) ? emerg_reg : hold_reg;
    assign timer_done  = CMP_W'(counter_inc) >= CMP_W'(timer_len);

    always_comb
    begin
        mode_next    = mode_reg;
        counter_next = counter_reg;
        fault        = 1'b0;

        // A sensor error outside connecting restarts the whole sequence.
        if (err_s1_reg && mode_reg != MODE_CONNECTING)
        begin
            mode_next    = MODE_CONNECTING;
            counter_next = '0;
            fault        = 1'b1;
        end
        else
        begin
            case (mode_reg)
                MODE_CONNECTING:
                begin
                    if (!err_s1_reg)
                        mode_next = MODE_OFF;
                end
                MODE_OFF:
                begin
                    if (above_low)
                    begin
                        counter_next = '0;
                        mode_next    = MODE_HALF;
                    end
                end
                MODE_HALF:
                begin
                    // On expiry the timer restarts and the reading is judged;
                    // going to full outranks going to off.
                    if (timer_done)
                    begin
                        counter_next = '0;
                        if (above_high)
                            mode_next = MODE_FULL;
                        else if (below_low)
                            mode_next = MODE_OFF;
                    end
                    else
                        counter_next = counter_inc;
                end
                MODE_FULL:
                begin
                    if (above_crit)
                    begin
                        counter_next = '0;
                        mode_next    = MODE_EMERGENCY;
                    end
                    else if (below_high)
                    begin
                        counter_next = '0;
                        mode_next    = MODE_HALF;
                    end
                end
                MODE_EMERGENCY:
                begin
                    if (timer_done)
                    begin
                        counter_next = '0;
                        mode_next    = MODE_LATCHED;
                    end
                    else
                        counter_next = counter_inc;
                end
                MODE_LATCHED:
                begin
                    if (key_s1_reg)
                        mode_next = MODE_CONNECTING;
                end
                default:
                begin
                    // Codes outside the mode list are treated as a restart.
                    mode_next    = MODE_CONNECTING;
                    counter_next = '0;
                    fault        = 1'b1;
                end
            endcase
        end
    end

    // Drive levels follow the mode handled on this tick; a restart drives nothing.
    logic [DUTY_W-1:0] duty;
    logic              water;

    always_comb
    begin
        duty  = DUTY_OFF;
        water = 1'b0;
        if (!fault)
        begin
            case (mode_reg)
                MODE_HALF:      duty  = DUTY_HALF;
                MODE_FULL:      duty  = DUTY_FULL;
                MODE_EMERGENCY: water = 1'b1;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CONNECTING;
            counter_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            counter_reg <= counter_next;
        end
    end

    // Result payload register.
    logic [DUTY_W-1:0] duty_reg;
    logic              water_reg;
    logic [2:0]        mode_out_reg;
    logic              fault_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_reg     <= duty;
            water_reg    <= water;
            mode_out_reg <= mode_next;
            fault_reg    <= fault;
        end
    end

    assign fan_duty      = duty_reg;
    assign water_on      = water_reg;
    assign mode          = mode_out_reg;
    assign fault_restart = fault_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The counter only runs in half fan and emergency; it is zero elsewhere.
    a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_CONNECTING || mode_reg == MODE_OFF ||
         mode_reg == MODE_FULL || mode_reg == MODE_LATCHED) |-> counter_reg == '0)
        else $error("tick counter not clear outside a timed mode");

    // A restart beat drives nothing and reports connecting.
    a_fault_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && fault_restart) |->
            (mode == MODE_CONNECTING && fan_duty == DUTY_OFF && !water_on))
        else $error("restart beat carries drive or a wrong mode");

    // Water is driven only from emergency, which leads to emergency or latched.
    a_water_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && water_on) |->
            ((mode == MODE_EMERGENCY || mode == MODE_LATCHED) && fan_duty == DUTY_OFF))
        else $error("water driven outside emergency");

    // The input side only stalls when the input register holds a beat
    // that cannot move on.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled without a blocked beat");

    // The mode register only changes when a beat moves to the result register.
    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg))
        else $error("mode changed without a beat");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ftmc_pkg::*;

    // Register indexes past the end of the map; writes there must be ignored.
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    // Longest run of cycles with no beat, result or register access before the
    // run is declared hung. The longest legal quiet stretch is the forced
    // receiver hold of HOLD_OFF_CYCLES plus the idle gaps around it.
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 60;

    // One expected result beat.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              water;
        mode_t             mode;
        logic              fault;
    } tick_result_t;

    // Tracks the thermostat's mode and tick counter, predicts the result of
    // every accepted tick and checks result beats against those predictions
    // in order.
    class thermo_scoreboard;
        logic [THR_W-1:0]            low_thr;
        logic [THR_W-1:0]            high_thr;
        logic [THR_W-1:0]            crit_thr;
        logic [TICKS_W-1:0]          hold_len;
        logic [TICKS_W-1:0]          emerg_len;
        mode_t                       cur_mode;
        logic [COUNTER_BITS_DEF-1:0] ticks;
        tick_result_t                expected_ticks[$];
        int                          errors;

        function new();
            low_thr   = LOW_THR_RST;
            high_thr  = HIGH_THR_RST;
            crit_thr  = CRIT_THR_RST;
            hold_len  = HOLD_RST;
            emerg_len = EMERG_RST;
            cur_mode  = MODE_CONNECTING;
            ticks     = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_LOW_THR:  low_thr   = data[THR_W-1:0];
                REG_HIGH_THR: high_thr  = data[THR_W-1:0];
                REG_CRIT_THR: crit_thr  = data[THR_W-1:0];
                REG_HOLD:     hold_len  = data[TICKS_W-1:0];
                REG_EMERG:    emerg_len = data[TICKS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_LOW_THR:  return DATA_W'(low_thr);
                REG_HIGH_THR: return DATA_W'(high_thr);
                REG_CRIT_THR: return DATA_W'(crit_thr);
                REG_HOLD:     return DATA_W'(hold_len);
                REG_EMERG:    return DATA_W'(emerg_len);
                default:      return '0;
            endcase
        endfunction

        // Counter saturates at all ones; a length of zero expires at once.
        function bit timer_expired(logic [TICKS_W-1:0] len);
            logic [COUNTER_BITS_DEF-1:0] next;
            next = ticks;
            if (next != '1)
                next = next + 1'b1;
            if (int'(next) >= int'(len))
            begin
                ticks = '0;
                return 1'b1;
            end
            ticks = next;
            return 1'b0;
        endfunction

        function void note_item(logic signed [TEMP_W-1:0] t, logic err, logic key);
            tick_result_t r;
            int           temp;
            int           lo;
            int           hi;
            int           crit;
            temp    = int'(t);
            lo      = int'(low_thr) * 10;
            hi      = int'(high_thr) * 10;
            crit    = int'(crit_thr) * 10;
            r.duty  = DUTY_OFF;
            r.water = 1'b0;
            r.fault = 1'b0;
            if (err && cur_mode != MODE_CONNECTING)
            begin
                cur_mode = MODE_CONNECTING;
                ticks    = '0;
                r.fault  = 1'b1;
            end
            else
            begin
                case (cur_mode)
                    MODE_CONNECTING:
                        if (!err)
                            cur_mode = MODE_OFF;
                    MODE_OFF:
                        if (temp > lo)
                        begin
                            ticks    = '0;
                            cur_mode = MODE_HALF;
                        end
                    MODE_HALF:
                    begin
                        r.duty = DUTY_HALF;
                        if (timer_expired(hold_len))
                        begin
                            if (temp < lo)
                                cur_mode = MODE_OFF;
                            if (temp > hi)
                                cur_mode = MODE_FULL;
                        end
                    end
                    MODE_FULL:
                    begin
                        r.duty = DUTY_FULL;
                        if (temp < hi)
                        begin
                            ticks    = '0;
                            cur_mode = MODE_HALF;
                        end
                        if (temp > crit)
                        begin
                            ticks    = '0;
                            cur_mode = MODE_EMERGENCY;
                        end
                    end
                    MODE_EMERGENCY:
                    begin
                        r.water = 1'b1;
                        if (timer_expired(emerg_len))
                            cur_mode = MODE_LATCHED;
                    end
                    default:
                        if (key)
                            cur_mode = MODE_CONNECTING;
                endcase
            end
            r.mode = cur_mode;
            expected_ticks.push_back(r);
        endfunction

        function void check_result(logic [DUTY_W-1:0] duty, logic water, logic [2:0] md,
                                   logic fault);
            tick_result_t want;
            if (expected_ticks.size() == 0)
            begin
                $error("result beat arrived with no expectation pending");
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            if (duty !== want.duty)
            begin
                $error("fan_duty: expected %0d, got %0d", want.duty, duty);
                errors++;
            end
            if (water !== want.water)
            begin
                $error("water_on: expected %0d, got %0d", want.water, water);
                errors++;
            end
            if (md !== want.mode)
            begin
                $error("mode: expected %0d, got %0d", want.mode, md);
                errors++;
            end
            if (fault !== want.fault)
            begin
                $error("fault_restart: expected %0d, got %0d", want.fault, fault);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     item_valid = 1'b0;
    logic                     item_stall;
    logic signed [TEMP_W-1:0] temperature_tenths = '0;
    logic                     sensor_error = 1'b0;
    logic                     key_pressed = 1'b0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [DUTY_W-1:0]        fan_duty;
    logic                     water_on;
    logic [2:0]               mode;
    logic                     fault_restart;

    thermo_scoreboard sb = new();

    // Per-phase idling style. In a burst phase the side never idles, so the
    // block sees back-to-back beats; otherwise a random gap may come before each beat.
    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;
    // Asks the result side for one long hold-off so the block backs up and
    // has to stall its input.
    bit hold_req   = 1'b0;
    int quiet_cycles = 0;

    fan_thermostat_mode_controller dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .item_valid         (item_valid),
        .item_stall         (item_stall),
        .temperature_tenths (temperature_tenths),
        .sensor_error       (sensor_error),
        .key_pressed        (key_pressed),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .fan_duty           (fan_duty),
        .water_on           (water_on),
        .mode               (mode),
        .fault_restart      (fault_restart)
    );

    always #6 clk = ~clk;

    // The watchdog restarts its count on any accepted beat on either channel
    // and on any register access, so it only fires when the block hangs.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Writes one register through the APB port, with random junk above the
    // register's width, then reads it back when the index is mapped. Each
    // call first waits for a clock edge so psel never gets two updates in one step.
    task automatic cfg_write(input logic [2:0] idx, input logic [TICKS_W-1:0] value);
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] got;
        if (idx == REG_HOLD || idx == REG_EMERG)
            data = ({$urandom} << TICKS_W) | DATA_W'(value);
        else
            data = ({$urandom} << THR_W) | DATA_W'(value[THR_W-1:0]);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, data);
        if (idx <= REG_EMERG)
        begin
            // Straight into the read-back setup phase; psel stays high.
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            got = prdata;
            if (got !== sb.reg_value(idx))
            begin
                $error("register %0d read-back: expected %0d, got %0d",
                       idx, sb.reg_value(idx), got);
                sb.errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one tick beat and holds it until the block takes it. The
    // prediction is made at the accepting edge.
    task automatic send_beat(input int t, input bit err, input bit key);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid         <= 1'b1;
        temperature_tenths <= t[TEMP_W-1:0];
        sensor_error       <= err;
        key_pressed        <= key;
        do @(posedge clk); while (item_stall);
        sb.note_item(t[TEMP_W-1:0], err, key);
    endtask

    // Most temperatures land within two degrees of one of the thresholds so
    // that strict compares and equality get exercised; one in ten spans the
    // whole 11-bit field, reaching every bit in both states.
    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        int v;
        case ($urandom_range(0, 9))
            0:       v = int'($urandom_range(0, 2047));
            1, 2, 3: v = int'(sb.low_thr) * 10 + int'($urandom_range(0, 40)) - 20;
            4, 5, 6: v = int'(sb.high_thr) * 10 + int'($urandom_range(0, 40)) - 20;
            default: v = int'(sb.crit_thr) * 10 + int'($urandom_range(0, 40)) - 20;
        endcase
        return v[TEMP_W-1:0];
    endfunction

    task automatic wait_for_drain();
        while (sb.expected_ticks.size() != 0)
            @(posedge clk);
    endtask

    // Sensor errors stay rare so the mode machine can climb all the way to
    // the latched state; key presses are common enough to leave it again.
    task automatic run_phase(input int lo, input int hi, input int crit, input int hold,
                             input int emerg, input int beats, input bit pressure);
        wait_for_drain();
        repeat (4) @(posedge clk);
        cfg_write(REG_LOW_THR, TICKS_W'(lo));
        cfg_write(REG_HIGH_THR, TICKS_W'(hi));
        cfg_write(REG_CRIT_THR, TICKS_W'(crit));
        cfg_write(REG_HOLD, TICKS_W'(hold));
        cfg_write(REG_EMERG, TICKS_W'(emerg));
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
        hold_req   = pressure;
        repeat (beats)
            send_beat(int'(pick_temperature()), $urandom_range(0, 99) < 3,
                      $urandom_range(0, 3) == 0);
        // With no beats sent the input is already idle.
        if (beats > 0)
            item_valid <= 1'b0;
    endtask

    // Result side: waits a random number of cycles before each beat, or the
    // long hold-off when asked, then takes the next beat and checks it.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = sink_burst ? 0 : $urandom_range(0, 4);
            if (hold_req)
            begin
                n        = HOLD_OFF_CYCLES;
                hold_req = 1'b0;
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            sb.check_result(fan_duty, water_on, mode, fault_restart);
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk at the reset register values: a sensor error while
        // connecting only holds the mode, an exact-threshold temperature
        // does not count as above, and an error in half duty forces a restart.
        send_beat(1023, 1'b1, 1'b1);
        send_beat(-1024, 1'b0, 1'b0);
        send_beat(230, 1'b0, 1'b0);
        send_beat(231, 1'b0, 1'b0);
        send_beat(231, 1'b1, 1'b0);
        item_valid <= 1'b0;

        // Directed walk with short timers (low 20, high 25, critical 30,
        // hold 2, emergency 3) through every mode and every transition but the error restart.
        run_phase(20, 25, 30, 2, 3, 0, 1'b0);
        send_beat(0, 1'b0, 1'b0);      // connecting to off
        send_beat(200, 1'b0, 1'b1);    // equal to low: stays off
        send_beat(201, 1'b0, 1'b0);    // off to half
        send_beat(300, 1'b0, 1'b0);
        send_beat(199, 1'b0, 1'b0);    // hold expires below low: back to off
        send_beat(500, 1'b0, 1'b0);
        send_beat(250, 1'b0, 1'b0);
        send_beat(251, 1'b0, 1'b0);    // hold expires above high: full
        send_beat(250, 1'b0, 1'b0);    // equal to high: stays full
        send_beat(249, 1'b0, 1'b0);    // below high: back to half
        send_beat(800, 1'b0, 1'b0);
        send_beat(800, 1'b0, 1'b0);
        send_beat(300, 1'b0, 1'b0);    // equal to critical: stays full
        send_beat(301, 1'b0, 1'b0);    // into emergency
        send_beat(-1, 1'b0, 1'b1);
        send_beat(0, 1'b0, 1'b0);
        send_beat(0, 1'b0, 1'b0);      // emergency time runs out: latched
        send_beat(0, 1'b0, 1'b0);      // no key: stays latched
        send_beat(0, 1'b0, 1'b1);      // key press: back to connecting
        send_beat(0, 1'b0, 1'b0);
        item_valid <= 1'b0;

        // Random phases. The first also holds the result side off for a long
        // stretch so the block backs up into its input.
        run_phase(23, 25, 27, 3, 4, 250, 1'b1);
        // Zero thresholds and zero-length timers, which expire every tick.
        run_phase(0, 0, 0, 0, 0, 150, 1'b0);
        // Largest values the registers hold.
        run_phase(127, 127, 127, 8191, 8191, 80, 1'b0);
        // Thresholds in reverse order, so the later compare in half and
        // full duty overrides the earlier one on the same tick.
        run_phase(40, 30, 20, 2, 5, 200, 1'b0);
        run_phase(99, 99, 99, 1, 1, 100, 1'b0);

        // Writes past the register map must leave every register untouched.
        wait_for_drain();
        cfg_write(REG_UNMAPPED_LO, TICKS_W'($urandom_range(0, 8191)));
        cfg_write(REG_UNMAPPED_HI, TICKS_W'($urandom_range(0, 8191)));

        repeat (4)
            run_phase($urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99),
                      $urandom_range(1, 12), $urandom_range(1, 12), 130, 1'b0);

        // Let the last results arrive, then keep the clock running to catch any
        // stray beat the block might still emit.
        wait_for_drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.expected_ticks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/ftmc_pkg.sv
sv/fan_thermostat_mode_controller.sv
tb/tb.sv
